@@ design/wsfp_pkg.sv @@
// ----------------------------------------------------------------------------
// wsfp_pkg: shared types and constants for the WebSocket frame parser
// Phase encoding, the result item layout and header field constants.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfp_pkg;

  localparam int unsigned LengthBitsDefault = 64;

  localparam logic [6:0] Len16Code = 7'd126;  // 16-bit extended length follows
  localparam logic [6:0] Len64Code = 7'd127;  // 64-bit extended length follows

  localparam logic [3:0] OpContinuation = 4'h0;
  localparam logic [3:0] OpText         = 4'h1;
  localparam logic [3:0] OpBinary       = 4'h2;

  typedef enum logic [2:0] {
    PhHdr0    = 3'd0,
    PhHdr1    = 3'd1,
    PhExtLen  = 3'd2,
    PhKey     = 3'd3,
    PhPayload = 3'd4,
    PhBad     = 3'd5
  } phase_e;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       frame_end;
    logic       final_fragment;
    logic       length_error;
  } result_t;

  function automatic logic is_data_op(input logic [3:0] op);
    is_data_op = (op == OpContinuation) || (op == OpText) || (op == OpBinary);
  endfunction

endpackage

`default_nettype wire

@@ design/wsfp_parser.sv @@
// ----------------------------------------------------------------------------
// wsfp_parser: frame header state machine and payload unmasking
// Consumes one byte per accepted item, produces at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfp_parser #(
  parameter int unsigned LENGTH_BITS = wsfp_pkg::LengthBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [7:0]        byte_i,
  output logic                   res_valid_o,
  output wsfp_pkg::result_t      res_o
);

  localparam logic [LENGTH_BITS-1:0] LenZero = '0;
  localparam logic [LENGTH_BITS-1:0] LenOne  = LENGTH_BITS'(1);
  localparam bit                     FullWidth = (LENGTH_BITS == 64);

  wsfp_pkg::phase_e        phase_q, phase_d;
  logic [2:0]              cnt_q, cnt_d;
  logic [LENGTH_BITS-1:0]  rem_q, rem_d;
  logic                    ovf_q, ovf_d;
  logic [31:0]             key_q, key_d;
  logic [1:0]              kidx_q, kidx_d;
  logic                    fin_q, fin_d;
  logic                    mask_q, mask_d;
  logic [3:0]              op_q, op_d;
  logic [6:0]              len7_q, len7_d;

  // extended length assembly
  logic [LENGTH_BITS-1:0]  rem_shift;
  logic                    ovf_next;
  logic                    ext_done;
  logic                    ext_err;
  logic                    need64;
  logic                    short_ext;
  logic [LENGTH_BITS-1:0]  short_len;
  logic [7:0]              key_byte;

  assign rem_shift = {rem_q[LENGTH_BITS-9:0], byte_i};
  // bytes shifted past the top of the counter make the length unusable
  assign ovf_next  = ovf_q | (|rem_q[LENGTH_BITS-1:LENGTH_BITS-8]);
  assign need64    = (len7_q == wsfp_pkg::Len64Code);
  assign ext_done  = need64 ? (cnt_q == 3'd7) : (cnt_q == 3'd1);
  assign ext_err   = need64 & (ovf_next | (FullWidth & rem_shift[LENGTH_BITS-1]));
  assign short_ext = (byte_i[6:0] == wsfp_pkg::Len16Code) ||
                     (byte_i[6:0] == wsfp_pkg::Len64Code);
  assign short_len = {{(LENGTH_BITS-7){1'b0}}, byte_i[6:0]};

  always_comb begin
    case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    ovf_d   = ovf_q;
    key_d   = key_q;
    kidx_d  = kidx_q;
    fin_d   = fin_q;
    mask_d  = mask_q;
    op_d    = op_q;
    len7_d  = len7_q;
    if (fire_i) begin
      case (phase_q)
        wsfp_pkg::PhHdr1: begin
          mask_d = byte_i[7];
          len7_d = byte_i[6:0];
          key_d  = '0;
          cnt_d  = '0;
          ovf_d  = 1'b0;
          kidx_d = '0;
          if (short_ext) begin
            rem_d   = LenZero;
            phase_d = wsfp_pkg::PhExtLen;
          end else begin
            rem_d = short_len;
            if (byte_i[7]) begin
              phase_d = wsfp_pkg::PhKey;
            end else if (byte_i[6:0] == 7'd0) begin
              phase_d = wsfp_pkg::PhHdr0;
            end else begin
              phase_d = wsfp_pkg::PhPayload;
            end
          end
        end
        wsfp_pkg::PhExtLen: begin
          rem_d = rem_shift;
          ovf_d = ovf_next;
          cnt_d = cnt_q + 3'd1;
          if (ext_done) begin
            cnt_d  = '0;
            kidx_d = '0;
            if (ext_err) begin
              phase_d = wsfp_pkg::PhBad;
            end else if (mask_q) begin
              phase_d = wsfp_pkg::PhKey;
            end else if (rem_shift == LenZero) begin
              phase_d = wsfp_pkg::PhHdr0;
            end else begin
              phase_d = wsfp_pkg::PhPayload;
            end
          end
        end
        wsfp_pkg::PhKey: begin
          key_d = {key_q[23:0], byte_i};
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd3) begin
            cnt_d   = '0;
            kidx_d  = '0;
            phase_d = (rem_q == LenZero) ? wsfp_pkg::PhHdr0 : wsfp_pkg::PhPayload;
          end
        end
        wsfp_pkg::PhPayload: begin
          kidx_d = kidx_q + 2'd1;
          rem_d  = rem_q - LenOne;
          if (rem_q == LenOne) begin
            phase_d = wsfp_pkg::PhHdr0;
          end
        end
        wsfp_pkg::PhBad: begin
          phase_d = wsfp_pkg::PhBad;
        end
        default: begin  // frame start (also recovers odd phase codes)
          fin_d   = byte_i[7];
          op_d    = byte_i[3:0];
          phase_d = wsfp_pkg::PhHdr1;
        end
      endcase
    end
  end

  // result for the byte being accepted
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fire_i) begin
      case (phase_q)
        wsfp_pkg::PhHdr1: begin
          if (!short_ext && !byte_i[7] && byte_i[6:0] == 7'd0 &&
              wsfp_pkg::is_data_op(op_q)) begin
            res_valid_o          = 1'b1;
            res_o.frame_opcode   = op_q;
            res_o.frame_end      = 1'b1;
            res_o.final_fragment = fin_q;
          end
        end
        wsfp_pkg::PhExtLen: begin
          if (ext_done) begin
            if (ext_err) begin
              res_valid_o        = 1'b1;
              res_o.length_error = 1'b1;
            end else if (!mask_q && rem_shift == LenZero &&
                         wsfp_pkg::is_data_op(op_q)) begin
              res_valid_o          = 1'b1;
              res_o.frame_opcode   = op_q;
              res_o.frame_end      = 1'b1;
              res_o.final_fragment = fin_q;
            end
          end
        end
        wsfp_pkg::PhKey: begin
          if (cnt_q == 3'd3 && rem_q == LenZero && wsfp_pkg::is_data_op(op_q)) begin
            res_valid_o          = 1'b1;
            res_o.frame_opcode   = op_q;
            res_o.frame_end      = 1'b1;
            res_o.final_fragment = fin_q;
          end
        end
        wsfp_pkg::PhPayload: begin
          if (wsfp_pkg::is_data_op(op_q)) begin
            res_valid_o          = 1'b1;
            res_o.payload_valid  = 1'b1;
            res_o.data_byte      = byte_i ^ key_byte;
            res_o.frame_opcode   = op_q;
            res_o.frame_end      = (rem_q == LenOne);
            res_o.final_fragment = fin_q;
          end
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wsfp_pkg::PhHdr0;
      cnt_q   <= '0;
      rem_q   <= '0;
      ovf_q   <= 1'b0;
      key_q   <= '0;
      kidx_q  <= '0;
      fin_q   <= 1'b0;
      mask_q  <= 1'b0;
      op_q    <= '0;
      len7_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      ovf_q   <= ovf_d;
      key_q   <= key_d;
      kidx_q  <= kidx_d;
      fin_q   <= fin_d;
      mask_q  <= mask_d;
      op_q    <= op_d;
      len7_q  <= len7_d;
    end
  end

endmodule

`default_nettype wire

@@ design/wsfp_outbuf.sv @@
// ----------------------------------------------------------------------------
// wsfp_outbuf: two-entry result buffer
// Registers results and decouples the input side from receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfp_outbuf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire wsfp_pkg::result_t din_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output wsfp_pkg::result_t      dout_o
);

  wsfp_pkg::result_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              pop;

  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign dout_o  = slot0_q;
  assign pop     = valid_o & ready_i;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q + {1'b0, push_i} - {1'b0, pop};
    if (pop) begin
      if (cnt_q == 2'd2) begin
        slot0_d = slot1_q;
      end else if (push_i) begin
        slot0_d = din_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        slot0_d = din_i;
      end else begin
        slot1_d = din_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

`default_nettype wire

@@ design/websocket_frame_parser.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_parser: RFC 6455 frame deframer, one byte per item
// Parses headers, extended lengths and masking keys; emits unmasked data.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / rx_byte_i) takes one stream byte
//   per item. Output channel (out_valid_o / out_ready_i) gives zero or one
//   result item per input byte: a payload byte of a continuation, text or
//   binary frame, an empty-frame end marker, or a single length error.
//   Header bytes, key bytes and payloads of control/unknown frames give none.
// Output: each result is registered in the output buffer before it appears.
// Throughput: one byte per cycle, sustained, while the receiver keeps up;
//   the whole per-byte decision is a single pass of logic between the parse
//   state registers and a two-entry output buffer.
// Stalls: when the receiver holds out_ready_i low, the buffer absorbs up to
//   two results; in_ready_o drops only once both entries are occupied.
// Reset: rst_ni (async, low) returns the parser to the start of a frame,
//   clears the sticky length error and empties the output buffer.
// After a 64-bit length with its top bit (or any bit beyond LENGTH_BITS) set,
//   one length_error item is sent and every later byte is dropped until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_parser #(
  parameter int unsigned LENGTH_BITS = wsfp_pkg::LengthBitsDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            payload_valid_o,
  output logic [7:0]      data_byte_o,
  output logic [3:0]      frame_opcode_o,
  output logic            frame_end_o,
  output logic            final_fragment_o,
  output logic            length_error_o
);

  logic              fire;
  logic              res_valid;
  wsfp_pkg::result_t res;
  wsfp_pkg::result_t res_out;
  logic              space;

  // byte taken whenever the output buffer has a free entry
  assign in_ready_o = space;
  assign fire       = in_valid_i & space;

  wsfp_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsfp_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .din_i   (res),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .dout_o  (res_out)
  );

  assign payload_valid_o  = res_out.payload_valid;
  assign data_byte_o      = res_out.data_byte;
  assign frame_opcode_o   = res_out.frame_opcode;
  assign frame_end_o      = res_out.frame_end;
  assign final_fragment_o = res_out.final_fragment;
  assign length_error_o   = res_out.length_error;

endmodule

`default_nettype wire

@@ design/wsfp_checker.sv @@
// ----------------------------------------------------------------------------
// wsfp_checker: port-level checks for the WebSocket frame parser
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       payload_valid_o,
  input wire logic [7:0] data_byte_o,
  input wire logic [3:0] frame_opcode_o,
  input wire logic       frame_end_o,
  input wire logic       final_fragment_o,
  input wire logic       length_error_o
);

  logic err_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && length_error_o) begin
      err_seen_q <= 1'b1;
    end
  end

  // stalled result stays valid and keeps its byte, end, payload and error flags
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(data_byte_o) && $stable(frame_end_o) &&
       $stable(payload_valid_o) && $stable(length_error_o)))
    else $error("result changed while stalled");

  // error item carries nothing else
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && length_error_o) |->
      (!payload_valid_o && !frame_end_o && !final_fragment_o &&
       frame_opcode_o == 4'h0 && data_byte_o == 8'h00))
    else $error("length error item carries data");

  // a non-payload, non-error item is an empty-frame marker
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !payload_valid_o && !length_error_o) |->
      (frame_end_o && data_byte_o == 8'h00))
    else $error("empty item without end marker");

  // stream is dead after a delivered length error
  a_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_seen_q |-> !out_valid_o)
    else $error("result after length error");

endmodule

bind websocket_frame_parser wsfp_checker u_wsfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .payload_valid_o  (payload_valid_o),
  .data_byte_o      (data_byte_o),
  .frame_opcode_o   (frame_opcode_o),
  .frame_end_o      (frame_end_o),
  .final_fragment_o (final_fragment_o),
  .length_error_o   (length_error_o)
);

`default_nettype wire
